FILE: rtl/core/mean_filter_3x3_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef MEAN_FILTER_3X3_MACROS_SVH
`define MEAN_FILTER_3X3_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mf3_pkg.sv
// Package: widths, defaults, register indexes and divide constants of the 3x3 mean filter.
package mf3_pkg;

   localparam int PIX_W          = 8;
   localparam int SUM_W          = 12;   // 9 * 255 = 2295
   localparam int CFG_WIDTH_W    = 11;
   localparam int CFG_HEIGHT_W   = 16;
   localparam int CFG_DATA_W     = 16;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_MAX_WIDTH  = 1024;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

   // floor(s / 9) == (s * 7282) >> 16 for every s below 32768
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_idx_type;

endpackage

FILE: rtl/core/mean_filter_3x3.sv
// Top level: streaming 3x3 mean filter with two line stores and a four-stage pipeline.
// Throughput: one pixel per clock while the output is not stalled; the line stores are one-write, one-read memories.
// Order: the input item that completes a window passes s1, then the window with s2, then s3 into the output
// register; that item comes width+1 items after the pixel itself.
// Reset (synchronous, active high): counters, pipeline valids and window clear, req_stall is
// held high, width and height return to 640 and 480; line stores are not cleared.
`include "mean_filter_3x3_macros.svh"

module mean_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   // pixel input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PIX_W-1:0]        req_pixel_in,
   input  logic                    req_pad,
   // filtered pixel output channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_W-1:0]        rsp_pixel_out,
   output logic                    rsp_frame_end,
   // register write port
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_idx,
   input  logic [CFG_DATA_W-1:0]   csr_wdata
);

   // column index width, item counter width, and a width wide enough to clamp the register
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int IW = $clog2(MAX_WIDTH + 2);
   localparam int EW = (CFG_WIDTH_W > $clog2(MAX_WIDTH + 1)) ? CFG_WIDTH_W
                                                              : $clog2(MAX_WIDTH + 1);

   // effective width minus one: zero acts as one, too wide acts as MAX_WIDTH
   function automatic logic [CW-1:0] width_m1(input logic [CFG_WIDTH_W-1:0] raw);
      logic [EW-1:0] e;
      e = EW'(raw);
      if (e == '0) begin
         e = EW'(1);
      end else if (e > EW'(MAX_WIDTH)) begin
         e = EW'(MAX_WIDTH);
      end
      return CW'(e - EW'(1));
   endfunction

   function automatic logic [CFG_HEIGHT_W-1:0] height_m1(input logic [CFG_HEIGHT_W-1:0] raw);
      return (raw == '0) ? '0 : raw - CFG_HEIGHT_W'(1);
   endfunction

   //--------------------------------------------------------------------------
   // Frame geometry (set by register writes) and position counters (updated at the input transfer)
   //--------------------------------------------------------------------------
   logic [CW-1:0]           wm1_ff;      // width - 1
   logic [CFG_HEIGHT_W-1:0] hm1_ff;      // height - 1
   logic [CW-1:0]           col_ff;      // column of the next input item
   logic [CFG_HEIGHT_W-1:0] row_ff;      // row of the next result
   logic [IW-1:0]           items_ff;    // items this frame, saturates at width + 1

   logic                    acc;
   logic [CW-1:0]           ic;          // column this item lands in
   logic [CW-1:0]           oc;          // column of the result it releases
   logic [CW-1:0]           col_in;
   logic                    acc_res;     // item releases a result
   logic                    acc_row_end;
   logic                    acc_row_last;
   logic                    acc_border;
   logic                    acc_last;
   logic [PIX_W-1:0]        acc_pix;

   // pipeline flow control
   logic                    out_ready;
   logic                    s3_free;
   logic                    s2_free;
   logic                    s1_adv;

   assign acc = req_valid && !req_stall;

   always_comb begin
      ic           = (col_ff > wm1_ff) ? '0 : col_ff;
      col_in       = (ic == wm1_ff) ? '0 : ic + CW'(1);
      oc           = (ic == '0) ? wm1_ff : ic - CW'(1);
      acc_res      = items_ff > (IW'(wm1_ff) + IW'(1));
      acc_row_end  = (oc == wm1_ff);
      acc_row_last = (row_ff >= hm1_ff);
      acc_border   = (row_ff == '0) || acc_row_last || (oc == '0) || acc_row_end;
      acc_last     = acc_row_last && acc_row_end;
      acc_pix      = req_pad ? '0 : req_pixel_in;   // flush items shift in zero
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff   <= width_m1(RESET_WIDTH);
         hm1_ff   <= height_m1(RESET_HEIGHT);
         col_ff   <= '0;
         row_ff   <= '0;
         items_ff <= '0;
      end else if (csr_we) begin
         // any register write restarts the frame
         unique case (csr_idx_type'(csr_idx))
            CSR_IMAGE_WIDTH:  wm1_ff <= width_m1(csr_wdata[CFG_WIDTH_W-1:0]);
            CSR_IMAGE_HEIGHT: hm1_ff <= height_m1(csr_wdata[CFG_HEIGHT_W-1:0]);
         endcase
         col_ff   <= '0;
         row_ff   <= '0;
         items_ff <= '0;
      end else if (acc) begin
         col_ff <= col_in;
         if (!acc_res) begin
            items_ff <= items_ff + IW'(1);
         end else if (acc_last) begin
            col_ff   <= '0;
            row_ff   <= '0;
            items_ff <= '0;
         end else if (acc_row_end) begin
            row_ff <= row_ff + CFG_HEIGHT_W'(1);
         end
      end
   end

   //--------------------------------------------------------------------------
   // Line stores: read at the input transfer, written when the item leaves s1
   //--------------------------------------------------------------------------
   logic [PIX_W-1:0] la_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] lta_mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_la_ff;
   logic [PIX_W-1:0] rd_lta_ff;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_la_ff;
   logic [PIX_W-1:0] fwd_lta_ff;
   logic [PIX_W-1:0] la_eff;
   logic [PIX_W-1:0] lta_eff;

   // stage 1: item with its line store column
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_ic_ff;
   logic             s1_res_ff;
   logic             s1_border_ff;
   logic             s1_last_ff;

   // same column written and read at one edge (width 1, or frame wrap): bypass the store
   assign la_eff  = fwd_ff ? fwd_la_ff  : rd_la_ff;
   assign lta_eff = fwd_ff ? fwd_lta_ff : rd_lta_ff;

   always_ff @(posedge clock) begin
      if (acc) begin
         rd_la_ff  <= la_mem[ic];
         rd_lta_ff <= lta_mem[ic];
      end
      if (s1_adv) begin
         la_mem[s1_ic_ff]  <= s1_pix_ff;
         lta_mem[s1_ic_ff] <= la_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (acc) begin
         fwd_ff <= s1_adv && (s1_ic_ff == ic);
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         fwd_la_ff  <= s1_pix_ff;
         fwd_lta_ff <= la_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff    <= acc_pix;
         s1_ic_ff     <= ic;
         s1_res_ff    <= acc_res;
         s1_border_ff <= acc_border;
         s1_last_ff   <= acc_last;
      end
   end

   //--------------------------------------------------------------------------
   // Window: shifts left by one column each time an item leaves s1.
   // s1 only moves when s2 is free, so the window matches the item in s2.
   //--------------------------------------------------------------------------
   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= lta_eff;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= la_eff;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_pix_ff;
      end
   end

   //--------------------------------------------------------------------------
   // Stage 2: window sum.  Stage 3: divide by 9 and select border pass-through.
   //--------------------------------------------------------------------------
   logic             s2_valid_ff;
   logic             s2_border_ff;
   logic             s2_last_ff;
   logic [SUM_W-1:0] s2_sum;

   logic             s3_valid_ff;
   logic [SUM_W-1:0] s3_sum_ff;
   logic [PIX_W-1:0] s3_center_ff;
   logic             s3_border_ff;
   logic             s3_last_ff;
   logic [PROD_W-1:0] s3_prod;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_frame_end_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_ready;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_adv    = s1_valid_ff && s2_free;
   // no transfer is taken while reset is high
   assign req_stall = reset || (s1_valid_ff && !s2_free);

   always_comb begin
      s2_sum = '0;
      for (int k = 0; k < 9; k++) begin
         s2_sum = s2_sum + SUM_W'(win_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv && s1_res_ff;   // warm-up items end here
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_border_ff <= s1_border_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free && s2_valid_ff) begin
         s3_sum_ff    <= s2_sum;
         s3_center_ff <= win_ff[4];
         s3_border_ff <= s2_border_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   assign s3_prod = PROD_W'(s3_sum_ff) * PROD_W'(RECIP_9);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         rsp_pixel_ff     <= s3_border_ff ? s3_center_ff : s3_prod[RECIP_SHIFT +: PIX_W];
         rsp_frame_end_ff <= s3_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   `MF3_ASSERT_NEXT(a_frame_restart, acc && acc_res && acc_last,
      (col_ff == '0) && (row_ff == '0) && (items_ff == '0), "frame end did not restart counters")
   `MF3_ASSERT_NOW(a_col_in_range, 1'b1, col_ff <= wm1_ff, "column counter beyond width")
   `MF3_ASSERT_NOW(a_items_sat, 1'b1, items_ff <= (IW'(wm1_ff) + IW'(2)),
      "item counter passed width + 1")

endmodule
